/* rtl/ircl_pkg.sv */
// ircl_pkg: shared constants, codes and types of the IPv4 range classifier.
// No dependencies; imported by every module of the block.
package ircl_pkg;

    localparam int LOW_BITS   = 16;
    localparam int MAX_RANGES = 8;
    localparam int TAG_BITS   = 16;
    localparam int BKT_BITS   = 32 - LOW_BITS;
    localparam int IDX_BITS   = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_BITS   = $clog2(MAX_RANGES + 1);
    localparam int ENT_BITS   = TAG_BITS + 2 * LOW_BITS;
    localparam int RNG_ABITS  = BKT_BITS + IDX_BITS;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_DEL    = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DUP     = 3'd1;
    localparam logic [2:0] ST_ORDER   = 3'd2;
    localparam logic [2:0] ST_OVERLAP = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;
    localparam logic [2:0] ST_MISSING = 3'd5;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [LOW_BITS-1:0] hi;
        logic [LOW_BITS-1:0] lo;
    } entry_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] addr;
        logic [31:0] rstart;
        logic [31:0] rend;
        logic [15:0] tag;
    } req_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [2:0]  status;
    } res_t;

endpackage

/* rtl/ipv4_range_classifier_table_top.sv */
// Top level of the IPv4 range classifier: stream ports, APB register,
// output register. Depends on ircl_pkg and ircl_engine.
//
//  channel  | dir | fields
//  s_axis   | in  | tuser: command; tdata: address, start, end, value tag
//  m_axis   | out | tdata: result tag, status
//  apb      | in  | default_tag at byte address 0
//
// After reset a clearing pass over all 65536 buckets empties the bucket counts;
// no item is taken meanwhile, register writes are.
// Lookup: a scan of the n ranges in the bucket, one entry at a time,
// through the single read port of the range store.
// Add/delete: per bucket a count read, entry scan, shift, pieces written, count write.
// One item at a time; a stalled result holds in the output register.
module ipv4_range_classifier_table_top
    import ircl_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] lookup_address, [63:32] range_start, [95:64] range_end,
    // [111:96] value_tag
    input  logic [111:0] s_tdata,
    // [1:0] command
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] result_tag, [18:16] status, [23:19] zero
    output logic [23:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    logic [15:0] dflt_reg;
    logic        m_valid_reg;
    res_t        m_res_reg;
    req_t        req;
    res_t        res;
    logic        res_valid, res_ready;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, dflt_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dflt_reg <= '0;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            dflt_reg <= pwdata[15:0];
        end
    end

    assign req.cmd    = s_tuser;
    assign req.addr   = s_tdata[31:0];
    assign req.rstart = s_tdata[63:32];
    assign req.rend   = s_tdata[95:64];
    assign req.tag    = s_tdata[111:96];

    assign res_ready = !m_valid_reg || m_tready;

    ircl_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .dflt_tag  (dflt_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) m_res_reg <= res;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_res_reg.status, m_res_reg.tag};

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("engine still ready after taking an item");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[18:16] != 3'd6 && m_tdata[18:16] != 3'd7))
        else $error("undefined status code");

    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && paddr[2] == 1'b0)
        |=> (paddr[2] || prdata[15:0] == $past(pwdata[15:0])))
        else $error("default tag not updated");

    a_result_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> (!m_tvalid || $past(res_valid)))
        else $error("result repeated");
endmodule

/* rtl/ircl_cnt_mem.sv */
// ircl_cnt_mem: per-bucket range count memory, one write and one read port.
// Depends on ircl_pkg.
module ircl_cnt_mem
    import ircl_pkg::*;
(
    input  logic                aclk,
    input  logic                we,
    input  logic [BKT_BITS-1:0] waddr,
    input  logic [CNT_BITS-1:0] wdata,
    input  logic [BKT_BITS-1:0] raddr,
    output logic [CNT_BITS-1:0] rdata
);
    logic [CNT_BITS-1:0] mem [2**BKT_BITS];
    logic [CNT_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/ircl_rng_mem.sv */
// ircl_rng_mem: range entry store, addressed by {bucket, slot}.
// Depends on ircl_pkg.
module ircl_rng_mem
    import ircl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 we,
    input  logic [RNG_ABITS-1:0] waddr,
    input  entry_t               wdata,
    input  logic [RNG_ABITS-1:0] raddr,
    output entry_t               rdata
);
    entry_t mem [2**RNG_ABITS];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/ircl_engine.sv */
// ircl_engine: sequencer for lookup, add and delete over both memories,
// with one compare unit that looks at one stored entry per step.
// Depends on ircl_pkg, ircl_cnt_mem, ircl_rng_mem.
module ircl_engine
    import ircl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    input  logic [15:0] dflt_tag,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res
);
    localparam logic [3:0] S_CLR      = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_CNT_RD   = 4'd2;
    localparam logic [3:0] S_CNT_GET  = 4'd3;
    localparam logic [3:0] S_SCAN_RD  = 4'd4;
    localparam logic [3:0] S_SCAN_CMP = 4'd5;
    localparam logic [3:0] S_PLAN     = 4'd6;
    localparam logic [3:0] S_SH_RD    = 4'd7;
    localparam logic [3:0] S_SH_WR    = 4'd8;
    localparam logic [3:0] S_WR       = 4'd9;
    localparam logic [3:0] S_CNT_WR   = 4'd10;
    localparam logic [3:0] S_NEXT     = 4'd11;
    localparam logic [3:0] S_DONE     = 4'd12;

    localparam logic [CNT_BITS-1:0] N_MAX  = CNT_BITS'(MAX_RANGES);
    localparam logic [CNT_BITS-1:0] N_MAX1 = CNT_BITS'(MAX_RANGES - 1);
    localparam logic [CNT_BITS-1:0] ONE    = CNT_BITS'(1);

    logic [3:0]          state_reg;
    logic [BKT_BITS-1:0] clr_reg;
    logic [BKT_BITS-1:0] h_reg, he_reg;
    logic [LOW_BITS-1:0] s_reg, e_reg, elow_reg;
    logic [1:0]          cmd_reg;
    logic [TAG_BITS-1:0] tag_reg, rtag_reg;
    logic [2:0]          st_reg;
    logic [CNT_BITS-1:0] n_reg, j_reg, i_reg, p_reg, nnew_reg;
    logic [1:0]          k_reg;
    logic                found_reg, up_reg;
    entry_t              ent_reg;
    logic [CNT_BITS-1:0] wa_reg [3];
    entry_t              wd_reg [3];
    logic [1:0]          wn_reg, wi_reg;

    logic                cnt_we;
    logic [BKT_BITS-1:0] cnt_waddr;
    logic [CNT_BITS-1:0] cnt_wdata, cnt_rdata;
    logic                rng_we;
    logic [CNT_BITS-1:0] rng_wslot;
    entry_t              rng_wdata, r;
    entry_t              new_ent;
    logic [BKT_BITS-1:0] h_inc;

    assign new_ent = '{tag: tag_reg, hi: e_reg, lo: s_reg};
    assign h_inc   = h_reg + BKT_BITS'(1);

    assign cnt_we    = (state_reg == S_CLR) || (state_reg == S_CNT_WR);
    assign cnt_waddr = (state_reg == S_CLR) ? clr_reg : h_reg;
    assign cnt_wdata = (state_reg == S_CLR) ? '0 : nnew_reg;

    assign rng_we    = (state_reg == S_SH_WR) || (state_reg == S_WR);
    always_comb begin
        if (state_reg == S_SH_WR) begin
            rng_wslot = up_reg ? (j_reg + CNT_BITS'(k_reg)) : (j_reg - ONE);
            rng_wdata = r;
        end else begin
            rng_wslot = wa_reg[wi_reg];
            rng_wdata = wd_reg[wi_reg];
        end
    end

    ircl_cnt_mem u_cnt (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (h_reg),
        .rdata (cnt_rdata)
    );

    ircl_rng_mem u_rng (
        .aclk  (aclk),
        .we    (rng_we),
        .waddr ({h_reg, rng_wslot[IDX_BITS-1:0]}),
        .wdata (rng_wdata),
        .raddr ({h_reg, j_reg[IDX_BITS-1:0]}),
        .rdata (r)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.tag    = 16'(rtag_reg);
    assign res.status = st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
        end else begin
            unique case (state_reg)
                S_CLR: begin
                    clr_reg <= clr_reg + BKT_BITS'(1);
                    if (&clr_reg) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (req_valid) begin
                        cmd_reg  <= req.cmd;
                        tag_reg  <= TAG_BITS'(req.tag);
                        st_reg   <= ST_OK;
                        rtag_reg <= '0;
                        elow_reg <= req.rend[LOW_BITS-1:0];
                        he_reg   <= req.rend[31:LOW_BITS];
                        if (req.cmd == CMD_LOOKUP) begin
                            h_reg     <= req.addr[31:LOW_BITS];
                            s_reg     <= req.addr[LOW_BITS-1:0];
                            state_reg <= S_CNT_RD;
                        end else if (req.cmd == CMD_ADD || req.cmd == CMD_DEL) begin
                            h_reg <= req.rstart[31:LOW_BITS];
                            s_reg <= req.rstart[LOW_BITS-1:0];
                            e_reg <= (req.rstart[31:LOW_BITS] == req.rend[31:LOW_BITS]) ?
                                     req.rend[LOW_BITS-1:0] : '1;
                            if (req.rstart > req.rend) begin
                                st_reg    <= ST_ORDER;
                                state_reg <= S_DONE;
                            end else begin
                                state_reg <= S_CNT_RD;
                            end
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_CNT_RD: state_reg <= S_CNT_GET;
                S_CNT_GET: begin
                    n_reg <= cnt_rdata;
                    if (cmd_reg == CMD_LOOKUP) begin
                        rtag_reg  <= TAG_BITS'(dflt_tag);
                        j_reg     <= '0;
                        state_reg <= (cnt_rdata == '0) ? S_DONE : S_SCAN_RD;
                    end else if (cmd_reg == CMD_ADD) begin
                        found_reg <= 1'b0;
                        j_reg     <= cnt_rdata - ONE;
                        state_reg <= (cnt_rdata == '0) ? S_PLAN : S_SCAN_RD;
                    end else begin
                        j_reg <= '0;
                        if (cnt_rdata == '0) begin
                            st_reg    <= ST_MISSING;
                            state_reg <= S_NEXT;
                        end else begin
                            state_reg <= S_SCAN_RD;
                        end
                    end
                end
                S_SCAN_RD: state_reg <= S_SCAN_CMP;
                S_SCAN_CMP: begin
                    if (cmd_reg == CMD_LOOKUP) begin
                        if (s_reg >= r.lo && s_reg <= r.hi) rtag_reg <= r.tag;
                        j_reg     <= j_reg + ONE;
                        state_reg <= (j_reg == n_reg - ONE) ? S_DONE : S_SCAN_RD;
                    end else if (cmd_reg == CMD_ADD) begin
                        if (e_reg < r.lo) begin
                            j_reg     <= j_reg - ONE;
                            state_reg <= (j_reg == '0) ? S_PLAN : S_SCAN_RD;
                        end else begin
                            found_reg <= 1'b1;
                            ent_reg   <= r;
                            i_reg     <= j_reg;
                            state_reg <= S_PLAN;
                        end
                    end else begin
                        if (r.lo == s_reg && r.hi == e_reg) begin
                            nnew_reg <= n_reg - ONE;
                            up_reg   <= 1'b0;
                            j_reg    <= j_reg + ONE;
                            state_reg <= (j_reg == n_reg - ONE) ? S_CNT_WR : S_SH_RD;
                        end else if (j_reg == n_reg - ONE) begin
                            st_reg    <= ST_MISSING;
                            state_reg <= S_NEXT;
                        end else begin
                            j_reg     <= j_reg + ONE;
                            state_reg <= S_SCAN_RD;
                        end
                    end
                end
                S_PLAN: begin
                    // classify the piece against the highest entry it does not lie below
                    logic [CNT_BITS-1:0] p;
                    logic [1:0]          k;
                    logic                err;
                    p   = i_reg + ONE;
                    k   = 2'd1;
                    err = 1'b0;
                    wi_reg <= '0;
                    if (!found_reg || s_reg > ent_reg.hi) begin
                        if (!found_reg) p = '0;
                        if (n_reg >= N_MAX) begin
                            err = 1'b1;
                            st_reg <= ST_FULL;
                        end
                        wa_reg[0] <= p;
                        wd_reg[0] <= new_ent;
                        wn_reg    <= 2'd1;
                    end else if (s_reg == ent_reg.lo && e_reg == ent_reg.hi) begin
                        k = 2'd0;
                        wa_reg[0] <= i_reg;
                        wd_reg[0] <= new_ent;
                        wn_reg    <= 2'd1;
                        st_reg    <= ST_DUP;
                    end else if (s_reg > ent_reg.lo && e_reg < ent_reg.hi) begin
                        k = 2'd2;
                        if (n_reg >= N_MAX1) begin
                            err = 1'b1;
                            st_reg <= ST_FULL;
                        end
                        wa_reg[0] <= i_reg;
                        wd_reg[0] <= '{tag: ent_reg.tag, hi: s_reg - LOW_BITS'(1),
                                       lo: ent_reg.lo};
                        wa_reg[1] <= i_reg + ONE;
                        wd_reg[1] <= new_ent;
                        wa_reg[2] <= i_reg + CNT_BITS'(2);
                        wd_reg[2] <= '{tag: ent_reg.tag, hi: ent_reg.hi,
                                       lo: e_reg + LOW_BITS'(1)};
                        wn_reg    <= 2'd3;
                    end else if (s_reg == ent_reg.lo && e_reg < ent_reg.hi) begin
                        if (n_reg >= N_MAX) begin
                            err = 1'b1;
                            st_reg <= ST_FULL;
                        end
                        wa_reg[0] <= i_reg + ONE;
                        wd_reg[0] <= '{tag: ent_reg.tag, hi: ent_reg.hi,
                                       lo: e_reg + LOW_BITS'(1)};
                        wa_reg[1] <= i_reg;
                        wd_reg[1] <= new_ent;
                        wn_reg    <= 2'd2;
                    end else if (s_reg > ent_reg.lo && e_reg == ent_reg.hi) begin
                        if (n_reg >= N_MAX) begin
                            err = 1'b1;
                            st_reg <= ST_FULL;
                        end
                        wa_reg[0] <= i_reg;
                        wd_reg[0] <= '{tag: ent_reg.tag, hi: s_reg - LOW_BITS'(1),
                                       lo: ent_reg.lo};
                        wa_reg[1] <= i_reg + ONE;
                        wd_reg[1] <= new_ent;
                        wn_reg    <= 2'd2;
                    end else begin
                        err = 1'b1;
                        st_reg <= ST_OVERLAP;
                    end
                    p_reg    <= p;
                    k_reg    <= k;
                    nnew_reg <= n_reg + CNT_BITS'(k);
                    up_reg   <= 1'b1;
                    j_reg    <= n_reg - ONE;
                    if (err) begin
                        state_reg <= S_DONE;
                    end else if (k != 2'd0 && p < n_reg) begin
                        state_reg <= S_SH_RD;
                    end else begin
                        state_reg <= S_WR;
                    end
                end
                S_SH_RD: state_reg <= S_SH_WR;
                S_SH_WR: begin
                    if (up_reg) begin
                        j_reg     <= j_reg - ONE;
                        state_reg <= (j_reg == p_reg) ? S_WR : S_SH_RD;
                    end else begin
                        j_reg     <= j_reg + ONE;
                        state_reg <= (j_reg == n_reg - ONE) ? S_CNT_WR : S_SH_RD;
                    end
                end
                S_WR: begin
                    wi_reg    <= wi_reg + 2'd1;
                    state_reg <= (wi_reg == wn_reg - 2'd1) ? S_CNT_WR : S_WR;
                end
                S_CNT_WR: state_reg <= S_NEXT;
                S_NEXT: begin
                    if (h_reg == he_reg) begin
                        state_reg <= S_DONE;
                    end else begin
                        h_reg     <= h_inc;
                        s_reg     <= '0;
                        e_reg     <= (h_inc == he_reg) ? elow_reg : '1;
                        state_reg <= S_CNT_RD;
                    end
                end
                S_DONE: begin
                    if (res_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
